### rtl/core/eeac_pkg.sv
// shared types and constants for the ellipse angle correction core
// arctangent table and cordic word widths; no dependencies
package eeac_pkg;

	localparam int TABLE_LEN = 24;
	localparam int XW        = 34;   // rotation cordic x/y width
	localparam int ZW        = 33;   // angle accumulator width
	localparam int VW        = 52;   // vectoring x/y width after scaling
	localparam int KW        = 15;
	localparam int K_FRAC    = 12;

	typedef logic signed [XW-1:0] rot_t;
	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_t;

	function automatic ang_t atan_turn(input int idx);
		ang_t a;
		case (idx)
			0:  a = 33'sh020000000;
			1:  a = 33'sh012E4051E;
			2:  a = 33'sh009FB385B;
			3:  a = 33'sh0051111D4;
			4:  a = 33'sh0028B0D43;
			5:  a = 33'sh00145D7E1;
			6:  a = 33'sh000A2F61E;
			7:  a = 33'sh000517C55;
			8:  a = 33'sh00028BE53;
			9:  a = 33'sh000145F2F;
			10: a = 33'sh0000A2F98;
			11: a = 33'sh0000517CC;
			12: a = 33'sh000028BE6;
			13: a = 33'sh0000145F3;
			14: a = 33'sh00000A2FA;
			15: a = 33'sh00000517D;
			16: a = 33'sh0000028BE;
			17: a = 33'sh00000145F;
			18: a = 33'sh000000A30;
			19: a = 33'sh000000518;
			20: a = 33'sh00000028C;
			21: a = 33'sh000000146;
			22: a = 33'sh0000000A3;
			23: a = 33'sh000000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### rtl/core/eeac_rot_stage.sv
// one registered micro-rotation of the rotation cordic
// uses eeac_pkg for widths and the arctangent table
module eeac_rot_stage #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  eeac_pkg::rot_t      x_in,
	input  eeac_pkg::rot_t      y_in,
	input  eeac_pkg::ang_t      z_in,
	input  logic [1:0]          q_in,
	input  logic [eeac_pkg::KW-1:0] k_in,
	output logic                vld_s1,
	output eeac_pkg::rot_t      x_s1,
	output eeac_pkg::rot_t      y_s1,
	output eeac_pkg::ang_t      z_s1,
	output logic [1:0]          q_s1,
	output logic [eeac_pkg::KW-1:0] k_s1
);

	eeac_pkg::rot_t dx, dy;
	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= q_in;
			k_s1 <= k_in;
			if (!z_in[eeac_pkg::ZW-1]) begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - eeac_pkg::atan_turn(IDX);
			end else begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + eeac_pkg::atan_turn(IDX);
			end
		end
	end

endmodule

### rtl/core/eeac_vec_stage.sv
// one registered micro-rotation of the vectoring cordic
// uses eeac_pkg for widths and the arctangent table
module eeac_vec_stage #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  eeac_pkg::vec_t x_in,
	input  eeac_pkg::vec_t y_in,
	input  eeac_pkg::ang_t z_in,
	output logic           vld_s1,
	output eeac_pkg::vec_t x_s1,
	output eeac_pkg::vec_t y_s1,
	output eeac_pkg::ang_t z_s1
);

	eeac_pkg::vec_t dx, dy;
	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[eeac_pkg::VW-1]) begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + eeac_pkg::atan_turn(IDX);
			end else begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - eeac_pkg::atan_turn(IDX);
			end
		end
	end

endmodule

### rtl/core/encoder_ellipse_angle_correction_top.sv
// top level of the encoder ellipse angle correction core
// uses eeac_pkg, eeac_rot_stage and eeac_vec_stage
// Corrects the elliptical distortion of a magnetic angle sensor:
// angle_out = atan2(k*sin(theta), cos(theta)) wrapped to one turn, with
// 2^ANGLE_BITS units per turn and k = ratio_k in unsigned Q3.12 (zero acts
// as one lsb). One word is taken every clock while the pipeline advances.
// It holds one register per cordic micro-rotation, n = min(CORDIC_STAGES,
// 24) in each cordic, plus input, quadrant/scale-multiply, fold and
// rounding registers. The whole pipeline advances only when the output
// register is empty or being taken, so a downstream stall holds every stage.
module encoder_ellipse_angle_correction_top #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,      // ratio_k
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,        // angle_in [31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata         // angle_out [15:0]
);

	localparam int N     = (CORDIC_STAGES < eeac_pkg::TABLE_LEN) ?
		CORDIC_STAGES : eeac_pkg::TABLE_LEN;
	localparam int SHIFT = 32 - ANGLE_BITS;
	localparam int KW    = eeac_pkg::KW;

	// configured ratio
	logic [KW-1:0] ratio_k_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_k_q <= KW'(4096);
		end else if (cfg_we) begin
			ratio_k_q <= cfg_wdata;
		end
	end

	// global advance: output register empty or draining
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input stage: wrap, quadrant and residue
	logic            vld_s0;
	logic [1:0]      q_s0;
	eeac_pkg::ang_t  z_s0;
	logic [KW-1:0]   k_s0;
	logic [31:0]     phase;
	assign phase = {s_tdata[ANGLE_BITS-1:0], {SHIFT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s0 <= phase[31:30];
			z_s0 <= {3'b000, phase[29:0]};
			k_s0 <= (ratio_k_q == '0) ? KW'(1) : ratio_k_q;
		end
	end

	// rotation cordic chain
	logic           rv  [0:N];
	eeac_pkg::rot_t rx  [0:N];
	eeac_pkg::rot_t ry  [0:N];
	eeac_pkg::ang_t rz  [0:N];
	logic [1:0]     rq  [0:N];
	logic [KW-1:0]  rk  [0:N];

	assign rv[0] = vld_s0;
	assign rx[0] = eeac_pkg::rot_t'(34'sd536870912);
	assign ry[0] = '0;
	assign rz[0] = z_s0;
	assign rq[0] = q_s0;
	assign rk[0] = k_s0;

	for (genvar i = 0; i < N; i++) begin : g_rot
		eeac_rot_stage #(.IDX(i)) u_rot (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(rv[i]), .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
			.q_in(rq[i]), .k_in(rk[i]),
			.vld_s1(rv[i+1]), .x_s1(rx[i+1]), .y_s1(ry[i+1]), .z_s1(rz[i+1]),
			.q_s1(rq[i+1]), .k_s1(rk[i+1])
		);
	end

	// quadrant rotation and scaling by k
	eeac_pkg::rot_t qx, qy;
	always_comb begin
		case (rq[N])
			2'd1:    begin qx = -ry[N]; qy = rx[N];  end
			2'd2:    begin qx = -rx[N]; qy = -ry[N]; end
			2'd3:    begin qx = ry[N];  qy = -rx[N]; end
			default: begin qx = rx[N];  qy = ry[N];  end
		endcase
	end

	logic           vld_sm;
	eeac_pkg::vec_t x_sm, y_sm;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (en) begin
			vld_sm <= rv[N];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_sm <= eeac_pkg::VW'(qx) <<< eeac_pkg::K_FRAC;
			y_sm <= eeac_pkg::VW'(qy) * $signed({1'b0, rk[N]});
		end
	end

	// fold the left half plane into the right one
	logic           vld_sf;
	eeac_pkg::vec_t x_sf, y_sf;
	eeac_pkg::ang_t z_sf;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= vld_sm;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_sm[eeac_pkg::VW-1]) begin
				x_sf <= -x_sm;
				y_sf <= -y_sm;
				z_sf <= eeac_pkg::ang_t'(33'sh080000000);
			end else begin
				x_sf <= x_sm;
				y_sf <= y_sm;
				z_sf <= '0;
			end
		end
	end

	// vectoring cordic chain
	logic           vv [0:N];
	eeac_pkg::vec_t vx [0:N];
	eeac_pkg::vec_t vy [0:N];
	eeac_pkg::ang_t vz [0:N];

	assign vv[0] = vld_sf;
	assign vx[0] = x_sf;
	assign vy[0] = y_sf;
	assign vz[0] = z_sf;

	for (genvar i = 0; i < N; i++) begin : g_vec
		eeac_vec_stage #(.IDX(i)) u_vec (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vv[i]), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
			.vld_s1(vv[i+1]), .x_s1(vx[i+1]), .y_s1(vy[i+1]), .z_s1(vz[i+1])
		);
	end

	// round half up to the output resolution, wrap, and register
	logic [31:0] acc_rnd;
	logic [31:0] res;
	assign acc_rnd = vz[N][31:0] + (32'd1 << (SHIFT - 1));
	assign res     = acc_rnd >> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vv[N];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res[15:0];
		end
	end

endmodule

### verif/tb_top.sv
// self-checking bench for encoder_ellipse_angle_correction_top
// depends on the rtl core only; predicts each corrected angle in-bench
`timescale 1ns / 100ps

module tb_top;

	localparam int STAGES    = 16;
	localparam int LATENCY   = 2 * STAGES + 4;
	localparam int CYCLE_CAP = 400000;

	// arctangent of 2^-i, 2^32 units per turn
	localparam longint ARCTAN [STAGES] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
	};

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [31:0] angle_feed [$];     // words still to be offered
	logic [15:0] angle_expect [$];   // corrected angles awaiting output
	logic [14:0] ratio_now = 15'd4096;
	int          words_sent, words_seen, fail_cnt, cycle_cnt;
	int          burst_left, gap_left, rx_phase, hold_left;
	bit          hold_go, hold_done;
	rx_mode_e    rx_mode = RX_RANDOM;

	encoder_ellipse_angle_correction_top #(
		.ANGLE_BITS   (16),
		.CORDIC_STAGES(STAGES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// atan2(k*sin, cos) through rotation then vectoring cordic, bit exact
	function automatic logic [15:0] corrected_angle(logic [31:0] raw, logic [14:0] ratio);
		longint x, y, z, t, dx, dy, k, acc;
		logic [31:0] phase;
		logic [1:0] quad;
		phase = {raw[15:0], 16'h0000};
		quad  = phase[31:30];
		z = longint'(phase[29:0]);
		x = 64'sd1 <<< 29;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		// exact quarter-turn rotation
		case (quad)
			2'd1: begin t = x; x = -y; y = t; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		// zero ratio acts as one lsb
		k = (ratio == 0) ? 1 : longint'(ratio);
		x = x * 4096;
		y = y * k;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd1 <<< 31;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ARCTAN[i];
			end else begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end
		end
		acc = ((z & 64'hFFFF_FFFF) + 64'd32768) & 64'hFFFF_FFFF;
		return acc[31:16];
	endfunction

	// sender: bursts of random length, random gaps, some gapless bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				angle_expect.push_back(corrected_angle(s_tdata, ratio_now));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (angle_feed.size() > 0) begin
					s_tdata  <= angle_feed.pop_front();
					s_tvalid <= 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern per mode, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_phase  = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			rx_phase = (rx_phase + 1) % 7;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:    m_tready <= 1'b1;
					RX_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
					RX_PATTERN: m_tready <= (rx_phase < 4);
					default:    m_tready <= 1'b1;
				endcase
			end
		end
	end

	// monitor: compare every taken word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (angle_expect.size() == 0) begin
				$error("unexpected word angle_out=%0h", m_tdata);
				fail_cnt++;
			end else begin
				logic [15:0] want;
				want = angle_expect.pop_front();
				if (m_tdata !== want) begin
					$error("angle_out mismatch: expected %0h actual %0h", want, m_tdata);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic drain();
		while (angle_feed.size() > 0 || s_tvalid || angle_expect.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_ratio(logic [14:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		ratio_now = v;
	endtask

	task automatic load_directed();
		angle_feed.push_back(32'h0000_0000);
		angle_feed.push_back(32'h0000_4000);   // 90 degrees
		angle_feed.push_back(32'h0000_8000);   // 180 degrees
		angle_feed.push_back(32'h0000_C000);   // 270 degrees
		angle_feed.push_back(32'h0000_FFFF);
		angle_feed.push_back(32'h0000_2000);
		angle_feed.push_back(32'h0000_6000);
		angle_feed.push_back(32'h0000_0001);
		angle_feed.push_back(32'h7FFF_FFFF);   // upper bits dropped by wrap
		angle_feed.push_back(32'h8000_0000);
		angle_feed.push_back(32'hFFFF_FFFF);
		angle_feed.push_back(32'hFFFF_4000);
		angle_feed.push_back(32'h1234_5678);
	endtask

	task automatic load_random(int n);
		for (int i = 0; i < n; i++)
			angle_feed.push_back($urandom());
	endtask

	initial begin
		logic [14:0] ratios [6];
		ratios = '{15'd0, 15'd32767, 15'd1, 15'd2048, 15'd12000, 15'd4096};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset ratio first, no write
		rx_mode = RX_OPEN;
		load_directed();
		load_random(150);
		drain();

		foreach (ratios[p]) begin
			write_ratio(p == 4 ? 15'($urandom_range(1, 32766)) : ratios[p]);
			rx_mode = rx_mode_e'(p % 3);
			load_directed();
			load_random(170);
			// fill the pipe against a blocked output once
			if (p == 1)
				hold_go = 1'b1;
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d words sent, %0d taken, ratio 1.0 and six written settings",
			words_sent, words_seen);
		$display("including zero, full-scale and one-lsb ratios and a long output stall");
		if (fail_cnt == 0 && angle_expect.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/core/eeac_pkg.sv
rtl/core/eeac_rot_stage.sv
rtl/core/eeac_vec_stage.sv
rtl/core/encoder_ellipse_angle_correction_top.sv
verif/tb_top.sv
